// ===== hdl/pcq_pkg.sv =====
package pcq_pkg;

  // default bank geometry
  localparam int NUM_QUEUES_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 8;

  // fixed field widths
  localparam int ID_W   = 16;
  localparam int QIDX_W = 5;
  localparam int CNT_W  = 4;
  localparam int CAP_W  = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd5;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TAKE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ADDED  = 2'd0,
    ST_FULL   = 2'd1,
    ST_SERVED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

endpackage

// ===== hdl/pcq_in_if.sv =====
interface pcq_in_if import pcq_pkg::*; ();
  logic              valid;
  logic              ready;
  op_t               operation;
  logic [QIDX_W-1:0] queue_index;
  logic [ID_W-1:0]   entry_id;
  logic              urgent;

  modport source (
    output valid, operation, queue_index, entry_id, urgent,
    input  ready
  );

  modport sink (
    input  valid, operation, queue_index, entry_id, urgent,
    output ready
  );
endinterface

// ===== hdl/pcq_out_if.sv =====
interface pcq_out_if import pcq_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [ID_W-1:0]  served_id;
  logic [CNT_W-1:0] count_after;

  modport source (
    output valid, status, served_id, count_after,
    input  ready
  );

  modport sink (
    input  valid, status, served_id, count_after,
    output ready
  );
endinterface

// ===== hdl/per_class_queue_with_urgent_insert.sv =====
// channel   direction  handshake      payload
// in_chan   in         valid/ready    operation, queue_index, entry_id, urgent
// out_chan  out        valid/ready    status, served_id, count_after
// cfg_*     in         write enable   cfg_wdata = capacity_in_use
//
// items are worked on one at a time: accept and read the queue descriptor
// memory, then decide, write it back and write or read the entry memory, then
// load the output register
// rst_n is synchronous; it clears control state, the per-queue valid bits and
// the capacity (back to 5); no clearing pass over the memories is needed
// a full output register holds the block in its last step; in_chan.ready is
// high again as soon as the result moves into the output register
module per_class_queue_with_urgent_insert import pcq_pkg::*; #(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  pcq_in_if.sink           in_chan,
  pcq_out_if.source        out_chan,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  // widths derived from the bank geometry
  localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int MW      = SW + CW;
  localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SUMW    = CW + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_META,
    S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [CAP_W-1:0] cap_r;

  // item being worked on
  op_t               op_r;
  logic [QIDX_W-1:0] q_r;
  logic [ID_W-1:0]   id_r;
  logic              urg_r;

  // result waiting for the output register
  status_t         res_status_r;
  logic [CW-1:0]   res_cnt_r;

  // output register
  logic             out_valid_r;
  status_t          out_status_r;
  logic [ID_W-1:0]  out_id_r;
  logic [CNT_W-1:0] out_cnt_r;

  // queue descriptor memory: {head slot, count} per queue
  logic [MW-1:0]         meta_mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] meta_vld_r;
  logic [MW-1:0]         meta_rd_r;
  logic                  meta_hit_r;

  // entry memory, one ring of QUEUE_DEPTH slots per queue
  logic [ID_W-1:0] store_mem [ENTRIES];
  logic [ID_W-1:0] store_rd_r;

  logic          in_fire;
  logic          out_free;
  logic [QW-1:0] rd_qa;
  logic [QW-1:0] qa;
  logic          in_range;
  logic [SW-1:0] head;
  logic [CW-1:0] cnt;
  int            cap_lim;
  logic          full;
  logic [SW-1:0] head_prev;
  logic [SW-1:0] head_next;
  logic [SUMW-1:0] tail_sum;
  logic [SW-1:0] tail;
  logic          do_add;
  logic          do_take;
  logic [SW-1:0] head_new;
  logic [CW-1:0] cnt_new;
  logic [SW-1:0] slot;
  logic [AW-1:0] base;
  logic [AW-1:0] st_addr;
  logic          meta_we;
  logic          st_we;
  logic          st_re;
  status_t       status;
  logic [CW-1:0] cnt_after;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign rd_qa    = QW'(in_chan.queue_index);

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.served_id   = out_id_r;
  assign out_chan.count_after = out_cnt_r;

  // decision step, valid while in S_META
  always_comb begin
    in_range = (32'(q_r) < NUM_QUEUES);
    qa       = QW'(q_r);
    // a queue never written reads as empty with head at slot zero
    head = meta_hit_r ? meta_rd_r[MW-1:CW] : '0;
    cnt  = meta_hit_r ? meta_rd_r[CW-1:0] : '0;

    // capacity beyond the ring depth is clipped to the depth
    cap_lim = (32'(cap_r) > QUEUE_DEPTH) ? QUEUE_DEPTH : 32'(cap_r);
    full    = (32'(cnt) >= cap_lim);

    // ring slot arithmetic
    head_prev = (head == '0) ? SW'(QUEUE_DEPTH - 1) : head - SW'(1);
    head_next = (32'(head) + 1 >= QUEUE_DEPTH) ? '0 : head + SW'(1);
    tail_sum  = SUMW'(head) + SUMW'(cnt);
    tail      = (32'(tail_sum) >= QUEUE_DEPTH) ? SW'(tail_sum - SUMW'(QUEUE_DEPTH))
                                               : SW'(tail_sum);

    do_add  = in_range && (op_r == OP_ADD) && !full;
    do_take = in_range && (op_r == OP_TAKE) && (cnt != '0);

    head_new = head;
    cnt_new  = cnt;
    slot     = head;
    if (do_add) begin
      cnt_new = cnt + CW'(1);
      if (urg_r) begin
        // urgent entry goes in front of the head
        head_new = head_prev;
        slot     = head_prev;
      end else begin
        slot = tail;
      end
    end else if (do_take) begin
      cnt_new  = cnt - CW'(1);
      head_new = head_next;
    end

    base    = AW'(32'(qa) * QUEUE_DEPTH);
    st_addr = base + AW'(slot);

    if (!in_range) begin
      status    = (op_r == OP_TAKE) ? ST_EMPTY : ST_FULL;
      cnt_after = '0;
    end else if (op_r == OP_ADD) begin
      status    = do_add ? ST_ADDED : ST_FULL;
      cnt_after = cnt_new;
    end else begin
      status    = do_take ? ST_SERVED : ST_EMPTY;
      cnt_after = cnt_new;
    end

    meta_we = (state_r == S_META) && (do_add || do_take);
    st_we   = (state_r == S_META) && do_add;
    st_re   = (state_r == S_META) && do_take;
  end

  // descriptor memory, read on accept, written back in the decision step
  always_ff @(posedge clk) begin
    if (in_fire) begin
      meta_rd_r <= meta_mem[rd_qa];
    end
    if (meta_we) begin
      meta_mem[qa] <= {head_new, cnt_new};
    end
  end

  // per-queue valid bits stand in for the all-zero reset of the descriptors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_vld_r <= '0;
      meta_hit_r <= 1'b0;
    end else begin
      if (in_fire) begin
        meta_hit_r <= meta_vld_r[rd_qa];
      end
      if (meta_we) begin
        meta_vld_r[qa] <= 1'b1;
      end
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_addr] <= id_r;
    end
    if (st_re) begin
      store_rd_r <= store_mem[st_addr];
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // in S_DONE the output register is reloaded below instead
      if (out_valid_r && out_chan.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r    <= in_chan.operation;
            q_r     <= in_chan.queue_index;
            id_r    <= in_chan.entry_id;
            urg_r   <= in_chan.urgent;
            state_r <= S_META;
          end
        end
        S_META: begin
          res_status_r <= status;
          res_cnt_r    <= cnt_after;
          state_r      <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_id_r     <= (res_status_r == ST_SERVED) ? store_rd_r : '0;
            out_cnt_r    <= CNT_W'(res_cnt_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
